[hdl/nre_pkg.sv]
package nre_pkg;

  localparam int MAX_ATOMS       = 64;
  localparam int COORD_FRAC_BITS = 16;

  localparam int IDX_W  = $clog2(MAX_ATOMS);
  localparam int CNT_W  = $clog2(MAX_ATOMS + 1);
  localparam int Z_W    = 7;
  localparam int C_W    = 32;
  localparam int D_W    = C_W + 1;
  localparam int SQ_W   = 2 * D_W;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 3;
  localparam int NUM_W  = 2 * Z_W + 16 + COORD_FRAC_BITS;
  localparam int E_W    = 48;
  localparam int TOT_W  = 7;

  localparam int SQ_STEPS   = 4;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int DIV_STEPS  = NUM_W;
  localparam int ITER_W     = $clog2(NUM_W + 1);

  localparam logic [E_W-1:0] E_MAX = '1;

  localparam int ST_COIN = 0;
  localparam int ST_SAT  = 1;

  typedef struct packed {
    logic [Z_W-1:0]        atom_charge;
    logic signed [C_W-1:0] pos_x;
    logic signed [C_W-1:0] pos_y;
    logic signed [C_W-1:0] pos_z;
    logic                  last_atom;
  } atom_t;

  typedef struct packed {
    logic [E_W-1:0]   energy;
    logic [1:0]       status;
    logic [TOT_W-1:0] atom_total;
  } result_t;

  typedef struct packed {
    logic [Z_W-1:0] charge;
    logic [C_W-1:0] x;
    logic [C_W-1:0] y;
    logic [C_W-1:0] z;
  } atom_rec_t;

  typedef struct packed {
    logic store;
    logic start;
    logic rd_i;
    logic lat_i;
    logic rd_j;
    logic diff;
    logic sq;
    logic chk;
    logic sqrt;
    logic div_init;
    logic div;
    logic acc;
    logic next;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic zero;
    logic sq_last;
    logic sqrt_last;
    logic div_last;
    logic last_j;
    logic last_i;
    logic out_busy;
  } stat_t;

endpackage

[hdl/nre_ctrl.sv]
module nre_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          atom_go,
  input  logic          atom_last,
  input  nre_pkg::stat_t st,
  output nre_pkg::cmd_t  cmd,
  output logic          idle
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'h0001,
    S_START = 14'h0002,
    S_RDI   = 14'h0004,
    S_LATI  = 14'h0008,
    S_RDJ   = 14'h0010,
    S_DIFF  = 14'h0020,
    S_SQ    = 14'h0040,
    S_CHK   = 14'h0080,
    S_SQRT  = 14'h0100,
    S_DIVI  = 14'h0200,
    S_DIV   = 14'h0400,
    S_ACC   = 14'h0800,
    S_NEXT  = 14'h1000,
    S_DONE  = 14'h2000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.store = atom_go;
        if (atom_go && atom_last) state_next = S_START;
      end
      S_START: begin
        cmd.start  = 1'b1;
        state_next = st.few ? S_DONE : S_RDI;
      end
      S_RDI: begin
        cmd.rd_i   = 1'b1;
        state_next = S_LATI;
      end
      S_LATI: begin
        cmd.lat_i  = 1'b1;
        state_next = S_RDJ;
      end
      S_RDJ: begin
        cmd.rd_j   = 1'b1;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_SQ;
      end
      S_SQ: begin
        cmd.sq = 1'b1;
        if (st.sq_last) state_next = S_CHK;
      end
      S_CHK: begin
        cmd.chk    = 1'b1;
        state_next = st.zero ? S_NEXT : S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt = 1'b1;
        if (st.sqrt_last) state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div = 1'b1;
        if (st.div_last) state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_NEXT;
      end
      S_NEXT: begin
        cmd.next = 1'b1;
        if (!st.last_j) begin
          state_next = S_RDJ;
        end else if (st.last_i) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RDI;
        end
      end
      S_DONE: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[hdl/nre_dp.sv]
module nre_dp (
  input  logic             clk,
  input  logic             rst,
  input  nre_pkg::cmd_t    cmd,
  input  nre_pkg::atom_t   atom,
  input  logic             result_stall,
  output nre_pkg::stat_t   st,
  output logic             result_valid,
  output nre_pkg::result_t result
);

  localparam int IW = nre_pkg::IDX_W;
  localparam int CW = nre_pkg::CNT_W;

  nre_pkg::atom_rec_t mem [nre_pkg::MAX_ATOMS];
  nre_pkg::atom_rec_t rdata, ai, wrec;

  logic [IW-1:0] i_idx, j_idx, raddr;
  logic [CW-1:0] count;
  logic          ovf;

  logic [nre_pkg::D_W-1:0]    dx, dy, dz, msel;
  logic [2*nre_pkg::Z_W-1:0]  zz;
  logic [nre_pkg::SQ_W-1:0]   prod, acc, sq_p;
  logic [nre_pkg::ROOT_W-1:0] root;
  logic [nre_pkg::REM_W-1:0]  rem, s_rem, s_trial, d_rem, d_div;
  logic [nre_pkg::NUM_W-1:0]  num;
  logic [nre_pkg::ITER_W-1:0] iter;
  logic [nre_pkg::E_W-1:0]    energy;
  logic [nre_pkg::E_W:0]      e_sum;
  logic                       coin, sat, s_ge, d_ge, room;

  function automatic logic [nre_pkg::D_W-1:0] absd(logic [nre_pkg::C_W-1:0] a,
                                                   logic [nre_pkg::C_W-1:0] b);
    logic [nre_pkg::D_W-1:0] d;
    d = {a[nre_pkg::C_W-1], a} - {b[nre_pkg::C_W-1], b};
    return d[nre_pkg::D_W-1] ? -d : d;
  endfunction

  assign room = (count < CW'(nre_pkg::MAX_ATOMS));
  assign wrec = '{charge: atom.atom_charge, x: atom.pos_x, y: atom.pos_y, z: atom.pos_z};
  assign raddr = cmd.rd_i ? i_idx : j_idx;

  always_ff @(posedge clk) begin
    if (cmd.store && room) mem[count[IW-1:0]] <= wrec;
    if (cmd.rd_i || cmd.rd_j) rdata <= mem[raddr];
  end

  always_comb begin
    case (iter[1:0])
      2'd0:    msel = dx;
      2'd1:    msel = dy;
      default: msel = dz;
    endcase
  end
  assign sq_p = msel * msel;

  // one root bit per step, two radicand bits consumed
  assign s_rem   = {rem[nre_pkg::REM_W-3:0], acc[nre_pkg::SQ_W-1 -: 2]};
  assign s_trial = nre_pkg::REM_W'({root, 2'b01});
  assign s_ge    = (s_rem >= s_trial);

  // restoring divide, quotient shifts into num
  assign d_rem = {rem[nre_pkg::REM_W-2:0], num[nre_pkg::NUM_W-1]};
  assign d_div = nre_pkg::REM_W'(root);
  assign d_ge  = (d_rem >= d_div);

  assign e_sum = {1'b0, energy} + (nre_pkg::E_W + 1)'(num);

  always_ff @(posedge clk) begin
    iter <= (cmd.sq || cmd.sqrt || cmd.div) ? iter + 1'b1 : '0;
    if (cmd.start) begin
      i_idx  <= '0;
      energy <= '0;
      coin   <= 1'b0;
      sat    <= 1'b0;
    end
    if (cmd.rd_i) j_idx <= i_idx + 1'b1;
    if (cmd.lat_i) ai <= rdata;
    if (cmd.diff) begin
      dx <= absd(ai.x, rdata.x);
      dy <= absd(ai.y, rdata.y);
      dz <= absd(ai.z, rdata.z);
      zz <= ai.charge * rdata.charge;
    end
    if (cmd.sq) begin
      prod <= sq_p;
      acc  <= (iter == '0) ? '0 : acc + prod;
    end
    if (cmd.chk) begin
      if (acc == '0) coin <= 1'b1;
      root <= '0;
      rem  <= '0;
    end
    if (cmd.sqrt) begin
      rem  <= s_ge ? s_rem - s_trial : s_rem;
      root <= {root[nre_pkg::ROOT_W-2:0], s_ge};
      acc  <= acc << 2;
    end
    if (cmd.div_init) begin
      num <= {zz, {(nre_pkg::NUM_W - 2*nre_pkg::Z_W){1'b0}}};
      rem <= '0;
    end
    if (cmd.div) begin
      rem <= d_ge ? d_rem - d_div : d_rem;
      num <= {num[nre_pkg::NUM_W-2:0], d_ge};
    end
    if (cmd.acc) begin
      if (e_sum[nre_pkg::E_W]) begin
        energy <= nre_pkg::E_MAX;
        sat    <= 1'b1;
      end else begin
        energy <= e_sum[nre_pkg::E_W-1:0];
      end
    end
    if (cmd.next) begin
      if (st.last_j) i_idx <= i_idx + 1'b1;
      else           j_idx <= j_idx + 1'b1;
    end
    if (cmd.finish) begin
      result.energy <= energy;
      result.status[nre_pkg::ST_COIN] <= coin;
      result.status[nre_pkg::ST_SAT]  <= sat | ovf;
      result.atom_total <= (32'(count) > 127) ? nre_pkg::TOT_W'(127)
                                              : nre_pkg::TOT_W'(count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.store) begin
        if (room) count <= count + 1'b1;
        else      ovf   <= 1'b1;
      end
      if (cmd.finish) begin
        count        <= '0;
        ovf          <= 1'b0;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign st.few       = (count < CW'(2));
  assign st.zero      = (acc == '0);
  assign st.sq_last   = (iter == nre_pkg::ITER_W'(nre_pkg::SQ_STEPS - 1));
  assign st.sqrt_last = (iter == nre_pkg::ITER_W'(nre_pkg::SQRT_STEPS - 1));
  assign st.div_last  = (iter == nre_pkg::ITER_W'(nre_pkg::DIV_STEPS - 1));
  assign st.last_j    = (CW'(j_idx) + CW'(1) == count);
  assign st.last_i    = (CW'(i_idx) + CW'(2) == count);
  assign st.out_busy  = result_valid && result_stall;

endmodule

[hdl/nuclear_repulsion_energy_top.sv]
// Atoms load at one item per cycle while idle; items without last_atom give
// no result. After the last atom, each pair of stored atoms runs in turn
// through the bit-serial square root (33 steps) and divider (46 steps); a
// coincident pair skips both. One molecule in flight at a time.
// rst (synchronous, active high) empties the atom store, clears result_valid.
module nuclear_repulsion_energy_top (
  input  logic             clk,
  input  logic             rst,
  input  logic             atom_valid,
  output logic             atom_stall,
  input  nre_pkg::atom_t   atom,
  output logic             result_valid,
  input  logic             result_stall,
  output nre_pkg::result_t result
);

  nre_pkg::cmd_t  cmd;
  nre_pkg::stat_t st;
  logic           idle, atom_go;

  assign atom_stall = !idle;
  assign atom_go    = atom_valid && idle;

  nre_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .atom_go   (atom_go),
    .atom_last (atom.last_atom),
    .st        (st),
    .cmd       (cmd),
    .idle      (idle)
  );

  nre_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .atom         (atom),
    .result_stall (result_stall),
    .st           (st),
    .result_valid (result_valid),
    .result       (result)
  );

  a_last_busy: assert property (@(posedge clk) disable iff (rst)
    (atom_valid && !atom_stall && atom.last_atom) |=> atom_stall)
    else $error("block accepted an atom while summing");

  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.atom_total < 7'd2) |->
      (result.energy == '0 && !result.status[nre_pkg::ST_COIN]))
    else $error("nonzero energy for fewer than two atoms");

  a_sat_cause: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status[nre_pkg::ST_SAT]) |->
      (result.energy == nre_pkg::E_MAX ||
       32'(result.atom_total) == nre_pkg::MAX_ATOMS ||
       result.atom_total == 7'd127))
    else $error("saturation flag without cause");

endmodule
